### rtl/etf_pkg.sv
// shared constants, types and helpers for the escape time fractal pixel unit
// no dependencies
package etf_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int FRAME_WIDTH   = 1024;
  localparam int FRAME_HEIGHT  = 1024;

  localparam int PAL_AW = $clog2(PALETTE_DEPTH);

  localparam int FRAC_BITS = 27;
  localparam logic [16:0] K095 = 17'd62259;        // 0.95 in q0.16
  localparam logic [64:0] ESC_LIMIT = 65'd1 << 56;  // 4.0 in q8.54

  localparam int ADDR_W = 20;

  // configuration register indexes
  localparam logic REG_MAX_ITER = 1'b0;
  localparam logic REG_SUB_MODE = 1'b1;

  // input op codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_PAL   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_SCALE,
    S_UPDATE,
    S_READ,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic pal_wr;
    logic mul;
    logic scale;
    logic update;
    logic pal_rd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic iter_ok;
    logic escaped;
    logic on_screen;
    logic out_free;
  } status_t;

  // clamp a 40 bit signed value to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/etf_ctrl.sv
// controller state machine for the fractal pixel unit
// depends on etf_pkg
module etf_ctrl import etf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    op,
  input  status_t status,
  output logic    in_stall,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   accept;

  assign accept = in_valid && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && op == OP_PIXEL) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = status.iter_ok ? S_MUL : S_READ;
      end
      S_MUL:    state_next = S_SCALE;
      S_SCALE:  state_next = S_UPDATE;
      S_UPDATE: begin
        state_next = status.escaped ? S_READ : S_CHECK;
      end
      S_READ:   state_next = S_EMIT;
      S_EMIT: begin
        if (!status.on_screen || status.out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.load   = accept && (op == OP_PIXEL);
        cmd.pal_wr = accept && (op == OP_PAL);
      end
      S_MUL:    cmd.mul    = 1'b1;
      S_SCALE:  cmd.scale  = 1'b1;
      S_UPDATE: cmd.update = !status.escaped;
      S_READ:   cmd.pal_rd = 1'b1;
      S_EMIT:   cmd.emit   = status.on_screen && status.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### rtl/etf_dp.sv
// datapath: iteration registers, multipliers, palette memory and output register
// depends on etf_pkg
module etf_dp import etf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic [7:0]          max_iter,
  input  logic                sub_mode,
  input  logic signed [31:0]  z_re,
  input  logic signed [31:0]  z_im,
  input  logic signed [31:0]  c_re,
  input  logic signed [31:0]  c_im,
  input  logic signed [11:0]  pix_x,
  input  logic signed [11:0]  pix_y,
  input  logic [7:0]          pal_index,
  input  logic [31:0]         pal_color,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ADDR_W-1:0]   pixel_addr,
  output logic [31:0]         pixel_color,
  output logic [7:0]          iter_count
);

  logic signed [31:0] re, im, cr, ci;
  logic signed [31:0] nre, nim;
  logic [7:0]         n;
  logic               on_scr;
  logic [ADDR_W-1:0]  addr;

  logic signed [63:0] prr, pii, pri;
  logic [63:0]        scaled;
  logic [31:0]        pal_q;

  logic [31:0]        palette [PALETTE_DEPTH];

  logic signed [63:0] diff;
  logic signed [39:0] nr_w, ni_w, cr_w, ci_w;
  logic [64:0]        esc_sum;
  logic [PAL_AW-1:0]  rd_idx;
  logic               x_ok, y_ok;

  // next z, one add (subtract with sub_mode) and clamp per part
  assign diff = prr - pii;
  assign cr_w = 40'(cr);
  assign ci_w = 40'(ci);
  always_comb begin
    nr_w = 40'(diff >>> FRAC_BITS);
    ni_w = 40'(pri >>> (FRAC_BITS - 1));
    if (sub_mode) begin
      nr_w = nr_w - cr_w;
      ni_w = ni_w - ci_w;
    end else begin
      nr_w = nr_w + cr_w;
      ni_w = ni_w + ci_w;
    end
  end

  assign esc_sum = 65'(scaled) + 65'(pii);

  // count saturates at the top palette entry
  assign rd_idx = (int'(n) >= PALETTE_DEPTH) ? PAL_AW'(PALETTE_DEPTH - 1) : PAL_AW'(n);

  assign x_ok = (pix_x >= 0) && (int'(pix_x) < FRAME_WIDTH);
  assign y_ok = (pix_y >= 0) && (int'(pix_y) < FRAME_HEIGHT);

  assign status.iter_ok   = (n < max_iter);
  assign status.escaped   = (esc_sum > ESC_LIMIT);
  assign status.on_screen = on_scr;
  assign status.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      re     <= z_re;
      im     <= z_im;
      cr     <= c_re;
      ci     <= c_im;
      n      <= '0;
      on_scr <= x_ok && y_ok;
      addr   <= ADDR_W'(int'(pix_y) * FRAME_WIDTH + int'(pix_x));
    end
    if (cmd.mul) begin
      prr <= re * re;
      pii <= im * im;
      pri <= re * im;
    end
    if (cmd.scale) begin
      scaled <= 64'(64'(prr[63:16]) * 64'(K095))
              + 64'((64'(prr[15:0]) * 64'(K095)) >> 16);
      nre    <= sat32(nr_w);
      nim    <= sat32(ni_w);
    end
    if (cmd.update) begin
      re <= nre;
      im <= nim;
      n  <= n + 8'd1;
    end
  end

  // palette memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.pal_wr && int'(pal_index) < PALETTE_DEPTH) begin
      palette[PAL_AW'(pal_index)] <= pal_color;
    end
    if (cmd.pal_rd) begin
      pal_q <= palette[rd_idx];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_addr  <= addr;
      pixel_color <= pal_q;
      iter_count  <= n;
    end
  end

endmodule

### rtl/escape_time_fractal_pixel.sv
// top level of the escape time fractal pixel unit: config registers and wiring
// depends on etf_pkg, etf_ctrl and etf_dp
//
// Each op 0 beat iterates z = z*z + c (or z*z - c with sub_mode set) in signed
// q4.27 until the count reaches max_iter or 0.95*re^2 + im^2 exceeds 4, then
// looks up the palette at the final count (saturated to the top entry) and,
// if the pixel lies on the 1024 x 1024 frame, sends one result beat with the
// linear address row*1024 + column, the colour and the count; off-screen
// pixels give no beat. After the accept, each iteration runs check,
// multiply (re^2, im^2, re*im), scale and clamp, then update through the
// one shared iteration datapath; a limit stop adds a last check, an escape
// adds its full check-to-update pass, and the palette read and result load
// follow. The result load waits while the previous result beat is still
// stalled. An op 1 beat writes one palette entry in its accept cycle and
// gives no result. The input stalls while a pixel is in progress; a finished
// result waits in the output register so a new beat can be taken meanwhile.
// The palette holds garbage after reset until written. Registers: max_iter
// at byte 0 (reset 64), sub_mode at byte 4 (reset 0); write only while the
// unit is idle.
module escape_time_fractal_pixel import etf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  input  logic signed [31:0]  z_re,
  input  logic signed [31:0]  z_im,
  input  logic signed [31:0]  c_re,
  input  logic signed [31:0]  c_im,
  input  logic signed [11:0]  pix_x,
  input  logic signed [11:0]  pix_y,
  input  logic [7:0]          pal_index,
  input  logic [31:0]         pal_color,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ADDR_W-1:0]   pixel_addr,
  output logic [31:0]         pixel_color,
  output logic [7:0]          iter_count,
  // apb configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [7:0] max_iter;
  logic       sub_mode;
  logic       cfg_wr;
  logic       reg_sel;
  cmd_t       cmd;
  status_t    status;

  // register select is the word index, low address bits ignored
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= 8'd64;
      sub_mode <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_MAX_ITER: max_iter <= pwdata[7:0];
        REG_SUB_MODE: sub_mode <= pwdata[0];
        default: begin
          max_iter <= max_iter;
        end
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_sel)
      REG_MAX_ITER: prdata = {24'd0, max_iter};
      REG_SUB_MODE: prdata = {31'd0, sub_mode};
      default:      prdata = '0;
    endcase
  end

  // sequencing of load, iteration steps, palette access and result load
  etf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // arithmetic, palette and output register
  etf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .max_iter    (max_iter),
    .sub_mode    (sub_mode),
    .z_re        (z_re),
    .z_im        (z_im),
    .c_re        (c_re),
    .c_im        (c_im),
    .pix_x       (pix_x),
    .pix_y       (pix_y),
    .pal_index   (pal_index),
    .pal_color   (pal_color),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_addr  (pixel_addr),
    .pixel_color (pixel_color),
    .iter_count  (iter_count)
  );

endmodule

### tb/sv/escape_time_fractal_pixel_tb.sv
// self-checking testbench for the escape time fractal pixel unit
// depends on etf_pkg and escape_time_fractal_pixel; holds its own escape-count
// predictor and palette image and checks every result beat against them
module escape_time_fractal_pixel_tb;
  import etf_pkg::*;

  // slowest legal run: ~650 beats, each a full 255-iteration pixel plus the
  // longest gap and stall, taken several times over
  localparam int RUN_LIMIT = 6000000;
  localparam int SHOWN_MISMATCHES = 10;
  localparam logic [63:0] ESCAPE_BOUND = 64'd1 << 56;  // 4.0 in q8.54
  localparam logic [63:0] SCALE_095 = 64'd62259;        // 0.95 in q0.16
  localparam logic signed [31:0] Q_ONE = 32'sd1 << FRAC_BITS;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  // one input beat as the sender sees it
  typedef struct {
    logic               op;
    logic signed [31:0] zr;
    logic signed [31:0] zi;
    logic signed [31:0] cr;
    logic signed [31:0] ci;
    logic signed [11:0] px;
    logic signed [11:0] py;
    logic [7:0]         pidx;
    logic [31:0]        pcol;
  } job_t;

  // one result beat
  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [31:0]       color;
    logic [7:0]        count;
  } pixel_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // input channel
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = OP_PIXEL;
  logic signed [31:0] z_re = '0;
  logic signed [31:0] z_im = '0;
  logic signed [31:0] c_re = '0;
  logic signed [31:0] c_im = '0;
  logic signed [11:0] pix_x = '0;
  logic signed [11:0] pix_y = '0;
  logic [7:0]         pal_index = '0;
  logic [31:0]        pal_color = '0;

  // result channel
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ADDR_W-1:0] pixel_addr;
  logic [31:0]       pixel_color;
  logic [7:0]        iter_count;

  // configuration port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state: register shadows and palette image
  int         cfg_max_iter = 64;
  bit         cfg_sub = 1'b0;
  logic [31:0] palette_img [0:PALETTE_DEPTH-1];

  pixel_res_t pixel_due [$];   // results still owed by the block, oldest first
  int         mismatches = 0;
  bit         idling = 1'b1;   // random gaps and stalls on both sides
  int         stall_left = 0;

  escape_time_fractal_pixel u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .z_re        (z_re),
    .z_im        (z_im),
    .c_re        (c_re),
    .c_im        (c_im),
    .pix_x       (pix_x),
    .pix_y       (pix_y),
    .pal_index   (pal_index),
    .pal_color   (pal_color),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_addr  (pixel_addr),
    .pixel_color (pixel_color),
    .iter_count  (iter_count),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp32(longint v);
    if (v > longint'(Q_MAX)) begin
      return longint'(Q_MAX);
    end else if (v < longint'(Q_MIN)) begin
      return longint'(Q_MIN);
    end
    return v;
  endfunction

  // number of iterations before escape or the limit, in the current mode
  function automatic logic [7:0] escape_count(logic signed [31:0] zr, logic signed [31:0] zi,
                                              logic signed [31:0] cr, logic signed [31:0] ci);
    longint      re, im, nr, ni;
    logic [63:0] re_sq, im_sq, scaled;
    int          n;
    bit          escaped;
    re = zr;
    im = zi;
    n = 0;
    escaped = 1'b0;
    while (n < cfg_max_iter && !escaped) begin
      re_sq = re * re;
      im_sq = im * im;
      // 0.95*re^2 in two halves so nothing is lost below the binary point
      scaled = (re_sq >> 16) * SCALE_095 + (((re_sq & 64'hffff) * SCALE_095) >> 16);
      if (scaled + im_sq > ESCAPE_BOUND) begin
        escaped = 1'b1;
      end else begin
        // arithmetic shifts floor towards minus infinity
        nr = (re * re - im * im) >>> FRAC_BITS;
        ni = (re * im) >>> (FRAC_BITS - 1);
        if (cfg_sub) begin
          nr = nr - longint'(cr);
          ni = ni - longint'(ci);
        end else begin
          nr = nr + longint'(cr);
          ni = ni + longint'(ci);
        end
        re = clamp32(nr);
        im = clamp32(ni);
        n++;
      end
    end
    return n[7:0];
  endfunction

  // apply an accepted beat: palette write, or queue the pixel it owes
  function automatic void mirror_beat(job_t j);
    pixel_res_t r;
    logic [7:0] n;
    if (j.op == OP_PAL) begin
      palette_img[j.pidx] = j.pcol;
    end else begin
      n = escape_count(j.zr, j.zi, j.cr, j.ci);
      if (j.px >= 0 && j.px < FRAME_WIDTH && j.py >= 0 && j.py < FRAME_HEIGHT) begin
        r.addr = ADDR_W'(int'(j.py) * FRAME_WIDTH + int'(j.px));
        // count never exceeds 255, so it always lands inside the palette
        r.color = palette_img[n];
        r.count = n;
        pixel_due.push_back(r);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES) begin
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endtask

  // every result beat is compared with the oldest owed pixel
  always @(posedge clk) begin
    pixel_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pixel_due.size() == 0) begin
        flag_mismatch("unowed result beat, pixel_addr", '0, 32'(pixel_addr));
      end else begin
        want = pixel_due.pop_front();
        if (pixel_addr !== want.addr) begin
          flag_mismatch("pixel_addr", 32'(want.addr), 32'(pixel_addr));
        end
        if (pixel_color !== want.color) begin
          flag_mismatch("pixel_color", want.color, pixel_color);
        end
        if (iter_count !== want.count) begin
          flag_mismatch("iter_count", 32'(want.count), 32'(iter_count));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // gap shaping and result-side stalls
  // ---------------------------------------------------------------------------

  // mostly none, often a few cycles, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else begin
      stall_left = pick_gap();
    end
    out_stall = (stall_left != 0);
  end

  // ---------------------------------------------------------------------------
  // sender side; every task is entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // present one beat, hold it until taken, then mirror it into the predictor
  task automatic send_job(job_t j);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    op = j.op;
    z_re = j.zr;
    z_im = j.zi;
    c_re = j.cr;
    c_im = j.ci;
    pix_x = j.px;
    pix_y = j.py;
    pal_index = j.pidx;
    pal_color = j.pcol;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    mirror_beat(j);
    @(negedge clk);
  endtask

  // hold the sender off until every owed result has arrived
  task automatic drain_results();
    in_valid = 1'b0;
    while (pixel_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // as above, then sit out one worst-case pixel in case an off-screen one is
  // still iterating
  task automatic settle_block();
    in_valid = 1'b0;
    while (pixel_due.size() != 0) @(posedge clk);
    repeat (4 * cfg_max_iter + 16) @(posedge clk);
    @(negedge clk);
  endtask

  // apb write then read back the same register
  task automatic program_reg(logic [2:0] addr, logic [31:0] data, logic [31:0] mask);
    logic [31:0] readback;
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if ((readback & mask) !== (data & mask)) begin
      flag_mismatch("register readback", data & mask, readback & mask);
    end
  endtask

  // both registers, with junk in the unused upper bits of the write data
  task automatic apply_config(int max_iter_v, bit sub_v);
    settle_block();
    program_reg({REG_MAX_ITER, 2'b00}, ($urandom() & 32'hffffff00) | max_iter_v,
                32'h000000ff);
    program_reg({REG_SUB_MODE, 2'b00}, ($urandom() & 32'hfffffffe) | sub_v, 32'h1);
    cfg_max_iter = max_iter_v;
    cfg_sub = sub_v;
  endtask

  // ---------------------------------------------------------------------------
  // beat builders; unused fields of each kind carry random bits
  // ---------------------------------------------------------------------------

  function automatic job_t make_pixel(logic signed [31:0] zr, logic signed [31:0] zi,
                                      logic signed [31:0] cr, logic signed [31:0] ci,
                                      int x, int y);
    job_t j;
    j.op = OP_PIXEL;
    j.zr = zr;
    j.zi = zi;
    j.cr = cr;
    j.ci = ci;
    j.px = 12'(x);
    j.py = 12'(y);
    j.pidx = 8'($urandom());
    j.pcol = $urandom();
    return j;
  endfunction

  function automatic job_t make_pal(int idx, logic [31:0] col);
    job_t j;
    j = make_pixel($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    j.op = OP_PAL;
    j.pidx = 8'(idx);
    j.pcol = col;
    return j;
  endfunction

  // uniform over -2.0 .. 2.0 in q4.27, where most of the action is
  function automatic logic signed [31:0] around_two();
    return $urandom_range(0, 1 << 29) - (1 << 28);
  endfunction

  function automatic job_t random_job();
    job_t j;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      j = make_pal($urandom_range(0, 255), $urandom());
    end else begin
      j = make_pixel(around_two(), around_two(), around_two(), around_two(),
                     $urandom_range(0, FRAME_WIDTH - 1), $urandom_range(0, FRAME_HEIGHT - 1));
      if (pick < 22) begin
        // full-range operands: saturation and instant escape
        j.zr = $urandom();
        j.zi = $urandom();
        j.cr = $urandom();
        j.ci = $urandom();
      end else if (pick < 34) begin
        // start at the origin with c near the main body of the set, so that
        // long orbits are common; subtract mode mirrors the set
        j.zr = '0;
        j.zi = '0;
        j.cr = $urandom_range(0, 1 << 27) - (3 << 25);
        j.ci = $urandom_range(0, 1 << 27) - (1 << 26);
        if (cfg_sub) begin
          j.cr = -j.cr;
        end
      end
      if ($urandom_range(0, 6) == 0) begin
        // anywhere in the 12 bit range, mostly off screen
        j.px = 12'($urandom());
        j.py = 12'($urandom());
      end
    end
    return j;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // the palette is garbage after reset, so every entry is loaded first
  task automatic test_palette_load();
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      send_job(make_pal(i, $urandom()));
    end
  endtask

  // field extremes, saturation, the escape bound and off-screen pixels
  task automatic test_field_extremes();
    send_job(make_pal(0, 32'h00000000));
    send_job(make_pal(PALETTE_DEPTH - 1, 32'hffffffff));
    // origin never escapes: runs to the limit
    send_job(make_pixel('0, '0, '0, '0, 0, 0));
    // huge start point escapes before the first iteration
    send_job(make_pixel(Q_MAX, Q_MAX, Q_MAX, Q_MAX, FRAME_WIDTH - 1, FRAME_HEIGHT - 1));
    send_job(make_pixel(Q_MIN, Q_MIN, Q_MIN, Q_MIN, FRAME_WIDTH - 1, 0));
    // one step to a far c, then escape
    send_job(make_pixel('0, '0, Q_MAX, '0, 0, FRAME_HEIGHT - 1));
    send_job(make_pixel('0, '0, Q_MIN, Q_MIN, 517, 300));
    // 4.0 plus a large c overflows the real part: clamp high, then clamp low
    send_job(make_pixel(2 * Q_ONE, '0, Q_MAX, Q_MIN, 12, 34));
    send_job(make_pixel('0, 2 * Q_ONE, Q_MIN, Q_MAX, 56, 78));
    // sum exactly 4 keeps going; one lsb more escapes at once
    send_job(make_pixel('0, 2 * Q_ONE, '0, '0, 100, 200));
    send_job(make_pixel('0, 2 * Q_ONE + 1, '0, '0, 101, 200));
    // off screen on each side: no result beat
    send_job(make_pixel('0, '0, '0, '0, -1, 0));
    send_job(make_pixel('0, '0, '0, '0, FRAME_WIDTH, 5));
    send_job(make_pixel('0, '0, '0, '0, 3, -2048));
    send_job(make_pixel(Q_MAX, '0, '0, '0, 2047, 2047));
    drain_results();
  endtask

  // a limit of zero gives count zero whatever the operands
  task automatic test_zero_limit();
    apply_config(0, 1'b0);
    send_job(make_pixel('0, '0, '0, '0, 7, 9));
    send_job(make_pixel(Q_MAX, Q_MIN, Q_MAX, Q_MIN, FRAME_WIDTH - 1, FRAME_HEIGHT - 1));
    send_job(make_pixel('0, '0, '0, '0, -2048, FRAME_HEIGHT));
  endtask

  // top limit: the count reaches the last palette entry
  task automatic test_full_limit();
    apply_config(255, 1'b0);
    send_job(make_pixel('0, '0, '0, '0, FRAME_WIDTH - 1, FRAME_HEIGHT - 1));
    send_job(make_pixel('0, '0, Q_ONE / 2, Q_ONE / 2, 640, 480));
  endtask

  // z*z - c: bounded orbit, escaping orbit, and clamping from a negated minimum
  task automatic test_subtract_mode();
    apply_config(32, 1'b1);
    send_job(make_pixel('0, '0, Q_ONE / 4, '0, 1, 1));
    send_job(make_pixel('0, '0, Q_ONE, Q_ONE, 2, 2));
    send_job(make_pixel(2 * Q_ONE, '0, Q_MIN, '0, 3, 3));
    send_job(make_pixel(Q_ONE / 2, -Q_ONE / 2, -Q_ONE / 3, Q_ONE / 5, 4, 4));
  endtask

  // random beats across several register settings
  task automatic test_random_mix();
    int limits [8] = '{64, 255, 0, 17, 255, 1, 0, 100};
    bit modes [8]  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    int beats [8]  = '{60, 40, 30, 60, 30, 40, 60, 50};
    for (int p = 0; p < 8; p++) begin
      if (p == 6) begin
        apply_config($urandom_range(2, 254), 1'($urandom()));
      end else begin
        apply_config(limits[p], modes[p]);
      end
      // one phase runs flat out on both sides
      idling = (p != 3);
      for (int k = 0; k < beats[p]; k++) begin
        send_job(random_job());
        if (k % 45 == 44) begin
          drain_results();
        end
      end
    end
    idling = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------------

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_palette_load();
    test_field_extremes();
    test_zero_limit();
    test_full_limit();
    test_subtract_mode();
    test_random_mix();
    // all owed results in, then a worst-case pixel time for stray beats
    settle_block();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
